FILE: rtl/dit_pkg.sv
// Package for the dual interval timer tone unit: counter state type,
// mode/phase/format codes and the shared counter update functions.
// No dependencies.
`default_nettype none
package dit_pkg;

    localparam int COUNTERS_PER_SIDE_DEF = 3;
    localparam int SLOTS_PER_SIDE        = 3;

    // Counter modes after folding
    localparam logic [2:0] MODE_INT_ON_TC  = 3'd0;
    localparam logic [2:0] MODE_ONE_SHOT   = 3'd1;
    localparam logic [2:0] MODE_RATE_GEN   = 3'd2;
    localparam logic [2:0] MODE_SQUARE     = 3'd3;
    localparam logic [2:0] MODE_SW_STROBE  = 3'd4;
    localparam logic [2:0] MODE_HW_STROBE  = 3'd5;

    // Counter phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LOAD = 2'd1;
    localparam logic [1:0] PH_RUN  = 2'd2;
    localparam logic [1:0] PH_END  = 2'd3;

    // Load formats
    localparam logic [1:0] FMT_LATCH = 2'd0;
    localparam logic [1:0] FMT_LSB   = 2'd1;
    localparam logic [1:0] FMT_MSB   = 2'd2;
    localparam logic [1:0] FMT_BOTH  = 2'd3;

    // Register select code for a control word
    localparam logic [1:0] REG_CTRL = 2'd3;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  fmt;
        logic        bcd;
        logic [1:0]  phase;
        logic        outp;
        logic        gate;
        logic        msb_pend;
        logic [7:0]  low_hold;
        logic [15:0] latch;
        logic [15:0] value;
    } cnt_t;

    // Counter state after reset: everything zero except the output, which is high
    localparam cnt_t CNT_RESET = cnt_t'({3'd0, 2'd0, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0,
                                         8'd0, 16'd0, 16'd0});

    // Effective count (0 reads as full range) is at most n, n <= 3
    function automatic logic eff_le(logic [15:0] v, logic [1:0] n);
        eff_le = (v != 16'd0) && (v[15:4] == 12'd0) && (v[3:0] <= {2'b00, n});
    endfunction

    // One down count, binary or BCD
    function automatic logic [15:0] cnt_dec(logic [15:0] v, logic bcd);
        logic [3:0] u;
        logic [3:0] t;
        logic [3:0] h;
        logic [3:0] th;
        u  = v[3:0];
        t  = v[7:4];
        h  = v[11:8];
        th = v[15:12];
        if (!bcd) begin
            cnt_dec = v - 16'd1;
        end else begin
            if (u != 4'd0) begin
                u = u - 4'd1;
            end else begin
                u = 4'd9;
                if (t != 4'd0) begin
                    t = t - 4'd1;
                end else begin
                    t = 4'd9;
                    if (h != 4'd0) begin
                        h = h - 4'd1;
                    end else begin
                        h  = 4'd9;
                        // borrow out of thousands wraps modulo ten, invalid digits too
                        th = (th == 4'd0) ? 4'd9 :
                             (th > 4'd10) ? th - 4'd11 : th - 4'd1;
                    end
                end
            end
            cnt_dec = {th, h, t, u};
        end
    endfunction

    function automatic cnt_t cnt_load_new(cnt_t c, logic [15:0] n_in);
        cnt_t r;
        logic [15:0] n;
        r = c;
        n = n_in;
        unique case (r.mode)
            MODE_RATE_GEN: begin
                if (n == 16'd1) n = 16'd2;
                if (r.phase == PH_IDLE) r.phase = PH_LOAD;
            end
            MODE_SQUARE: begin
                if (n == 16'd1) n = 16'd0;
                if (r.phase == PH_IDLE) r.phase = PH_LOAD;
            end
            MODE_INT_ON_TC, MODE_SW_STROBE: r.phase = PH_LOAD;
            default: ;
        endcase
        r.latch = n;
        return r;
    endfunction

    // Zero-time update after a count load
    function automatic cnt_t cnt_settle(cnt_t c);
        cnt_t r;
        r = c;
        unique case (r.mode)
            MODE_INT_ON_TC: begin
                if (r.phase == PH_LOAD) r.value = r.latch;
            end
            MODE_ONE_SHOT: begin
                if (r.phase == PH_LOAD) begin
                    r.value = r.latch;
                    r.outp  = 1'b0;
                end
            end
            MODE_RATE_GEN: begin
                if (!r.gate || r.phase == PH_IDLE) r.outp = 1'b1;
                else if (r.phase == PH_LOAD) r.value = r.latch;
                else if (r.phase == PH_RUN && eff_le(r.value, 2'd1)) begin
                    r.phase = PH_END;
                    r.outp  = 1'b0;
                end
            end
            MODE_SQUARE: begin
                if (!r.gate || r.phase == PH_IDLE) r.outp = 1'b1;
                else if (r.phase == PH_LOAD) r.value = r.latch;
            end
            MODE_SW_STROBE, MODE_HW_STROBE: begin
                if (r.gate || r.mode == MODE_HW_STROBE) begin
                    if (r.phase == PH_LOAD) r.value = r.latch;
                    else if (r.phase == PH_RUN && r.value == 16'd0) begin
                        r.phase = PH_END;
                        r.outp  = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic cnt_t cnt_write_ctrl(cnt_t c, logic [7:0] d);
        cnt_t r;
        logic [2:0] m;
        r = c;
        m = d[3:1];
        if (d[5:4] != FMT_LATCH) begin
            if (m > MODE_HW_STROBE) m = {1'b0, m[1:0]};
            r.bcd      = d[0];
            r.fmt      = d[5:4];
            r.mode     = m;
            r.msb_pend = 1'b0;
            r.phase    = PH_IDLE;
            r.outp     = (m != MODE_INT_ON_TC);
        end
        return r;
    endfunction

    function automatic cnt_t cnt_write_count(cnt_t c, logic [7:0] b);
        cnt_t r;
        r = c;
        unique case (r.fmt)
            FMT_LSB, FMT_MSB: begin
                r = cnt_load_new(r, (r.fmt == FMT_LSB) ? {8'd0, b} : {b, 8'd0});
                r = cnt_settle(r);
                if (r.mode == MODE_INT_ON_TC) r.outp = 1'b0;
            end
            FMT_BOTH: begin
                if (r.msb_pend) begin
                    r = cnt_load_new(r, {b, r.low_hold});
                    r = cnt_settle(r);
                end else begin
                    r.low_hold = b;
                    if (r.mode == MODE_INT_ON_TC) begin
                        r.phase = PH_IDLE;
                        r.outp  = 1'b0;
                    end
                end
                r.msb_pend = !r.msb_pend;
            end
            default: ;
        endcase
        return r;
    endfunction

    // One timer clock
    function automatic cnt_t cnt_clock(cnt_t c);
        cnt_t r;
        r = c;
        unique case (r.mode)
            MODE_INT_ON_TC: begin
                if (r.phase == PH_LOAD) begin
                    r.phase = PH_RUN;
                    r.value = r.latch;
                end else if (r.phase == PH_RUN && r.gate) begin
                    if (eff_le(r.value, 2'd1)) begin
                        r.phase = PH_END;
                        r.value = 16'd0;
                        r.outp  = 1'b1;
                    end else begin
                        r.value = cnt_dec(r.value, r.bcd);
                    end
                end else if (r.phase == PH_END && r.gate) begin
                    r.value = cnt_dec(r.value, r.bcd);
                end
            end
            MODE_ONE_SHOT: begin
                if (r.phase == PH_LOAD) begin
                    r.phase = PH_RUN;
                    r.value = r.latch;
                    r.outp  = 1'b0;
                end else begin
                    if (r.phase == PH_RUN && eff_le(r.value, 2'd1)) begin
                        r.phase = PH_END;
                        r.outp  = 1'b1;
                    end
                    r.value = cnt_dec(r.value, r.bcd);
                end
            end
            MODE_RATE_GEN: begin
                if (!r.gate || r.phase == PH_IDLE) r.outp = 1'b1;
                else if (r.phase == PH_LOAD) begin
                    r.phase = PH_RUN;
                    r.value = r.latch;
                end else if (r.phase == PH_RUN) begin
                    if (eff_le(r.value, 2'd2)) begin
                        r.phase = PH_END;
                        r.outp  = 1'b0;
                    end
                    r.value = cnt_dec(r.value, r.bcd);
                end else begin
                    r.phase = PH_RUN;
                    r.value = r.latch;
                    r.outp  = 1'b1;
                end
            end
            MODE_SQUARE: begin
                if (!r.gate || r.phase == PH_IDLE) r.outp = 1'b1;
                else if (r.phase == PH_LOAD) begin
                    r.phase = PH_RUN;
                    r.value = r.latch;
                end else if (r.phase == PH_RUN) begin
                    if (eff_le(r.value, 2'd2)) begin
                        r.phase = PH_END;
                        r.value = r.latch;
                        r.outp  = 1'b0;
                    end
                    r.value = cnt_dec(r.value, r.bcd);
                end else begin
                    if (eff_le(r.value, 2'd3)) begin
                        r.phase = PH_RUN;
                        r.value = {r.latch[15:1], 1'b0};
                        r.outp  = 1'b1;
                    end
                    r.value = cnt_dec(r.value, r.bcd);
                end
            end
            MODE_SW_STROBE, MODE_HW_STROBE: begin
                if (r.gate || r.mode == MODE_HW_STROBE) begin
                    if (r.phase == PH_LOAD) begin
                        r.phase = PH_RUN;
                        r.value = r.latch;
                        if (r.value == 16'd0) begin
                            r.phase = PH_END;
                            r.outp  = 1'b0;
                        end
                    end else if (r.phase == PH_RUN) begin
                        if (r.value == 16'd0) begin
                            r.phase = PH_END;
                            r.outp  = 1'b0;
                            r.value = cnt_dec(16'd0, r.bcd);
                        end else if (eff_le(r.value, 2'd1)) begin
                            r.phase = PH_END;
                            r.outp  = 1'b0;
                            r.value = 16'd0;
                        end else begin
                            r.value = cnt_dec(r.value, r.bcd);
                        end
                    end else if (r.phase == PH_END) begin
                        r.phase = PH_IDLE;
                        r.value = cnt_dec(r.value, r.bcd);
                        r.outp  = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Shared gate change: gate rising retriggers modes 1, 2 and 5
    function automatic cnt_t cnt_set_gate(cnt_t c, logic g);
        cnt_t r;
        r = c;
        if (g != r.gate) begin
            r.gate = g;
            if (g && (r.mode == MODE_ONE_SHOT || r.mode == MODE_RATE_GEN ||
                      r.mode == MODE_HW_STROBE)) begin
                r.phase = PH_LOAD;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/dit_in_if.sv
// Input channel of the timer tone unit: valid/ready plus the item fields.
// No dependencies.
`default_nettype none
interface dit_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] bus_word;

    modport source (output valid, output operation, output bus_word, input ready);
    modport sink   (input valid, input operation, input bus_word, output ready);
endinterface
`default_nettype wire

FILE: rtl/dit_out_if.sv
// Result channel of the timer tone unit: valid/ready plus level fields.
// No dependencies.
`default_nettype none
interface dit_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] channel_levels;
    logic [1:0] left_active;
    logic [1:0] right_active;

    modport source (output valid, output channel_levels, output left_active,
                    output right_active, input ready);
    modport sink   (input valid, input channel_levels, input left_active,
                    input right_active, output ready);
endinterface
`default_nettype wire

FILE: rtl/dual_interval_timer_tone_unit_core.sv
// Top level of the dual interval timer tone unit.
// Depends on dit_pkg, dit_in_if and dit_out_if.
`default_nettype none
// Two banks of 8253-style counters behind one shared counter update unit.
// An accepted item (port word or timer tick) is applied to the counters one
// at a time, one counter per cycle: after the accept state (ST_IDLE) each
// present counter passes through the shared unit in turn (ST_RUN), then the
// result register is loaded (ST_HOLD) and ready rises again. The result
// register holds the gated levels until taken; a new item is accepted while
// it waits, but its own result is held back, and ready stays low, until the
// register is free.
module dual_interval_timer_tone_unit_core #(
    parameter int COUNTERS_PER_SIDE = dit_pkg::COUNTERS_PER_SIDE_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dit_in_if.sink     cmd,
    dit_out_if.source  res
);

    localparam int KW = (COUNTERS_PER_SIDE > 1) ? $clog2(COUNTERS_PER_SIDE) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(COUNTERS_PER_SIDE - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t         state_reg;
    logic           op_reg;
    logic [15:0]    word_reg;
    logic           side_reg;
    logic [KW-1:0]  k_reg;
    logic           strobe_prev_reg;
    logic           gate_prev_reg;
    logic           out_valid_reg;
    logic [5:0]     levels_reg;
    logic [1:0]     left_reg;
    logic [1:0]     right_reg;

    dit_pkg::cnt_t  cnt_reg [6];
    dit_pkg::cnt_t  cur;
    dit_pkg::cnt_t  cnt_next;

    logic [2:0]     slot;
    logic [1:0]     k_full;
    logic           w_gate;
    logic           w_strobe;
    logic           wr_edge;
    logic           side_sel;
    logic           hit;
    logic [5:0]     levels;
    logic [1:0]     left_cnt;
    logic [1:0]     right_cnt;
    logic           last_slot;

    // Inverted port word fields
    assign w_gate   = ~word_reg[15];
    assign w_strobe = ~word_reg[12];
    assign wr_edge  = strobe_prev_reg && !w_strobe;

    assign k_full    = 2'(k_reg);
    assign slot      = side_reg ? (3'd3 + {1'b0, k_full}) : {1'b0, k_full};
    assign cur       = cnt_reg[slot];
    assign last_slot = side_reg && (k_reg == K_LAST);

    // Does this port write address the current counter
    always_comb
    begin
        side_sel = side_reg ? ~word_reg[11] : ~word_reg[10];
        if (~word_reg[9:8] == dit_pkg::REG_CTRL)
            hit = wr_edge && side_sel && (~word_reg[7:6] == k_full);
        else
            hit = wr_edge && side_sel && (~word_reg[9:8] == k_full);
    end

    // Shared counter update unit
    always_comb
    begin
        cnt_next = cur;
        if (op_reg == dit_pkg::OP_TICK) begin
            cnt_next = dit_pkg::cnt_clock(cur);
        end else begin
            cnt_next = dit_pkg::cnt_set_gate(cur, w_gate);
            if (hit) begin
                if (~word_reg[9:8] == dit_pkg::REG_CTRL)
                    cnt_next = dit_pkg::cnt_write_ctrl(cnt_next, ~word_reg[7:0]);
                else
                    cnt_next = dit_pkg::cnt_write_count(cnt_next, ~word_reg[7:0]);
            end
        end
    end

    // Counter state store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 6; i++) begin
                cnt_reg[i] <= dit_pkg::CNT_RESET;
            end
        end else if (state_reg == ST_RUN) begin
            cnt_reg[slot] <= cnt_next;
        end
    end

    // Gated levels of present counters
    always_comb
    begin
        levels    = '0;
        left_cnt  = '0;
        right_cnt = '0;
        for (int k = 0; k < dit_pkg::SLOTS_PER_SIDE; k++) begin
            if (k < COUNTERS_PER_SIDE) begin
                levels[k]     = cnt_reg[k].gate && !cnt_reg[k].outp;
                levels[k + 3] = cnt_reg[k + 3].gate && !cnt_reg[k + 3].outp;
                left_cnt  = left_cnt + 2'(levels[k]);
                right_cnt = right_cnt + 2'(levels[k + 3]);
            end
        end
    end

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= ST_IDLE;
            op_reg          <= dit_pkg::OP_WRITE;
            word_reg        <= '1;
            side_reg        <= 1'b0;
            k_reg           <= '0;
            strobe_prev_reg <= 1'b0;
            gate_prev_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            levels_reg      <= '0;
            left_reg        <= '0;
            right_reg       <= '0;
        end else begin
            // result taken; a new one is loaded from ST_HOLD instead
            if (res.ready && state_reg != ST_HOLD)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd.valid) begin
                        op_reg    <= cmd.operation;
                        word_reg  <= cmd.bus_word;
                        side_reg  <= 1'b0;
                        k_reg     <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (last_slot) begin
                        if (op_reg == dit_pkg::OP_WRITE) begin
                            strobe_prev_reg <= w_strobe;
                            gate_prev_reg   <= w_gate;
                        end
                        state_reg <= ST_HOLD;
                    end else if (k_reg == K_LAST) begin
                        side_reg <= 1'b1;
                        k_reg    <= '0;
                    end else begin
                        k_reg <= k_reg + KW'(1);
                    end
                end
                ST_HOLD: begin
                    if (!out_valid_reg || res.ready) begin
                        out_valid_reg <= 1'b1;
                        levels_reg    <= levels;
                        left_reg      <= left_cnt;
                        right_reg     <= right_cnt;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign cmd.ready          = (state_reg == ST_IDLE);
    assign res.valid          = out_valid_reg;
    assign res.channel_levels = levels_reg;
    assign res.left_active    = left_reg;
    assign res.right_active   = right_reg;

    // Checks
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !cmd.ready)
        else $error("ready high while an item is in progress");

    a_left_count: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (32'(res.left_active) == $countones(res.channel_levels[2:0])))
        else $error("left active count mismatch");

    a_right_count: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (32'(res.right_active) == $countones(res.channel_levels[5:3])))
        else $error("right active count mismatch");

    a_gate_shared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cnt_reg[0].gate == gate_prev_reg))
        else $error("counter gate out of step with shared gate");

endmodule
`default_nettype wire
